// File: rtl/core/peer_discovery_handshake_core_macros.svh
// Assertion macros for the peer discovery handshake core.
// Included by the RTL files that carry concurrent assertions.
`ifndef PEER_DISCOVERY_HANDSHAKE_CORE_MACROS_SVH
`define PEER_DISCOVERY_HANDSHAKE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property at every rising clock edge outside reset.
`define PDH_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pdh assertion failed");
// Check a property at every rising clock edge, reset included.
`define PDH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pdh assertion failed");
`else
`define PDH_ASSERT(label, clk, rst, prop)
`define PDH_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/core/pdh_pkg.sv
// Shared types and constants for the peer discovery handshake core.
// No dependencies; used by peer_discovery_handshake_core.
package pdh_pkg;

  localparam int TIME_BITS_DEF = 32;

  typedef enum logic [1:0] {
    PH_PING    = 2'd0,
    PH_VERSION = 2'd1,
    PH_STATUS  = 2'd2,
    PH_IDLE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    H_OFFLINE     = 2'd0,
    H_DISCOVERING = 2'd1,
    H_READY       = 2'd2,
    H_DEGRADED    = 2'd3
  } health_t;

  typedef enum logic [2:0] {
    E_NONE       = 3'd0,
    E_WRITE      = 3'd1,
    E_PEER       = 3'd2,
    E_UNEXPECTED = 3'd3,
    E_VERSION    = 3'd4,
    E_TIMEOUT    = 3'd5,
    E_MALFORMED  = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    REQ_BEGIN     = 2'd0,
    REQ_FRAME     = 2'd1,
    REQ_PARSE_ERR = 2'd2,
    REQ_TICK      = 2'd3
  } req_t;

  localparam logic [2:0] CMD_ACK   = 3'd3;
  localparam logic [2:0] CMD_DATA  = 3'd4;
  localparam logic [2:0] CMD_ERROR = 3'd5;

  localparam logic [7:0] LEN_MIN     = 8'd2;
  localparam logic [7:0] LEN_PING    = 8'd2;
  localparam logic [7:0] LEN_VERSION = 8'd5;
  localparam logic [7:0] LEN_STATUS  = 8'd4;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ATT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEARTBEAT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REDISCOVER = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EXP_VER    = 3'd4;

  localparam logic [15:0] TIMEOUT_RST    = 16'd100;
  localparam logic [7:0]  MAX_ATT_RST    = 8'd3;
  localparam logic [31:0] HEARTBEAT_RST  = 32'd1000;
  localparam logic [31:0] REDISCOVER_RST = 32'd5000;
  localparam logic [7:0]  EXP_VER_RST    = 8'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        write_ok;
    logic [2:0]  frame_cmd;
    logic [7:0]  payload_len;
    logic [7:0]  echo_req;
    logic [7:0]  peer_version;
    logic [7:0]  payload_b2;
    logic [7:0]  payload_b3;
    logic [7:0]  payload_b4;
  } in_word_t;

  typedef struct packed {
    logic        send_valid;
    logic [1:0]  send_cmd;
    logic [1:0]  health;
    logic [2:0]  last_error;
    logic [7:0]  proto_version;
    logic [7:0]  fw_major;
    logic [7:0]  fw_minor;
    logic [7:0]  fw_patch;
    logic [7:0]  ready_bits;
    logic [7:0]  supported_bits;
    logic [31:0] failure_count;
    logic [31:0] discovery_count;
  } out_word_t;

endpackage

// File: rtl/core/peer_discovery_handshake_core.sv
// Master side of the peer discovery handshake: ping, get-version, get-status.
// Depends on pdh_pkg and peer_discovery_handshake_core_macros.svh.
//
// Usage:
//   in_valid/in_ready carry one event word (begin, decoded frame, parse error
//   or tick) with its millisecond timestamp and the write-accepted flag.
//   out_valid/out_ready carry exactly one result word per event: the request
//   sent on that event (if any) plus health, last error, version fields,
//   masks and the failure and discovery counters after the event.
//   cfg_we/cfg_idx/cfg_wdata write the five settings with no wait; write them
//   only while no event is in flight. Unknown indexes are ignored.
// Timing:
//   out_valid rises from the result register: one input register, then the state
//   update and result register in the same cycle, held while out_ready is low.
//   Throughput is one event per cycle while out_ready is high; the update is a
//   few compares and two time subtracts between input and result registers.
// Reset (rst, synchronous): settings return to defaults, link offline, phase
//   idle, counters and captured fields zero, both stages empty.
// Stall: while out_ready is low the result holds; one more event may sit in
//   the input register, after which in_ready drops until the result is taken.
module peer_discovery_handshake_core #(
  parameter int TIME_BITS = pdh_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pdh_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pdh_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [pdh_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [31:0]                         cfg_wdata
);
  import pdh_pkg::*;
  `include "peer_discovery_handshake_core_macros.svh"

  // Compare width covering both the elapsed time and 32-bit intervals.
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  // settings
  logic [15:0] timeout_ms;
  logic [7:0]  max_attempts;
  logic [31:0] heartbeat_ms;
  logic [31:0] rediscover_ms;
  logic [7:0]  exp_version;

  // input stage
  in_word_t s1;
  logic     s1_valid;
  logic     adv;
  logic     s1_fire;

  // block state
  phase_t               phase, phase_next;
  logic [7:0]           attempt_count, attempt_count_next;
  logic [TIME_BITS-1:0] req_start, req_start_next;
  logic [TIME_BITS-1:0] last_act, last_act_next;
  health_t              health, health_next;
  err_t                 error, error_next;
  logic [7:0]           proto_ver, proto_ver_next;
  logic [7:0]           fw_major, fw_major_next;
  logic [7:0]           fw_minor, fw_minor_next;
  logic [7:0]           fw_patch, fw_patch_next;
  logic [7:0]           ready_mask, ready_mask_next;
  logic [7:0]           supp_mask, supp_mask_next;
  logic [31:0]          fail_cnt, fail_cnt_next;
  logic [31:0]          disc_cnt, disc_cnt_next;

  // step decode
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] rsp_elapsed;
  logic [TIME_BITS-1:0] idle_elapsed;
  logic [31:0]          idle_interval;
  logic                 rsp_expired;
  logic                 idle_expired;
  logic                 issue_req;
  phase_t               issue_ph;
  logic                 issue_fresh;
  logic                 fail;
  err_t                 fail_err;
  logic                 sent;
  phase_t               sent_ph;

  assign adv      = !out_valid || out_ready;
  assign s1_fire  = s1_valid && adv;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms    <= TIMEOUT_RST;
      max_attempts  <= MAX_ATT_RST;
      heartbeat_ms  <= HEARTBEAT_RST;
      rediscover_ms <= REDISCOVER_RST;
      exp_version   <= EXP_VER_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TIMEOUT:    timeout_ms    <= cfg_wdata[15:0];
        CFG_MAX_ATT:    max_attempts  <= cfg_wdata[7:0];
        CFG_HEARTBEAT:  heartbeat_ms  <= cfg_wdata;
        CFG_REDISCOVER: rediscover_ms <= cfg_wdata;
        CFG_EXP_VER:    exp_version   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_data;
    end
  end

  assign now_t         = TIME_BITS'(s1.now_ms);
  assign rsp_elapsed   = now_t - req_start;
  assign idle_elapsed  = now_t - last_act;
  assign idle_interval = (health == H_OFFLINE) ? rediscover_ms : heartbeat_ms;
  assign rsp_expired   = CW'(rsp_elapsed) >= CW'(timeout_ms);
  assign idle_expired  = CW'(idle_elapsed) >= CW'(idle_interval);

  always_comb begin
    phase_next         = phase;
    attempt_count_next = attempt_count;
    req_start_next     = req_start;
    last_act_next      = last_act;
    health_next        = health;
    error_next         = error;
    proto_ver_next     = proto_ver;
    fw_major_next      = fw_major;
    fw_minor_next      = fw_minor;
    fw_patch_next      = fw_patch;
    ready_mask_next    = ready_mask;
    supp_mask_next     = supp_mask;
    fail_cnt_next      = fail_cnt;
    disc_cnt_next      = disc_cnt;
    issue_req          = 1'b0;
    issue_ph           = PH_PING;
    issue_fresh        = 1'b0;
    fail               = 1'b0;
    fail_err           = E_NONE;
    sent               = 1'b0;
    sent_ph            = PH_PING;

    case (req_t'(s1.req_type))
      REQ_BEGIN: begin
        health_next = H_DISCOVERING;
        error_next  = E_NONE;
        issue_req   = 1'b1;
        issue_ph    = PH_PING;
        issue_fresh = 1'b1;
      end
      REQ_FRAME: begin
        // Peer error wins over every other check.
        if (s1.frame_cmd == CMD_ERROR) begin
          fail     = 1'b1;
          fail_err = E_PEER;
        end else if (phase == PH_IDLE || s1.payload_len < LEN_MIN ||
                     s1.echo_req != 8'(phase)) begin
          fail     = 1'b1;
          fail_err = E_UNEXPECTED;
        end else if (s1.peer_version != exp_version) begin
          fail     = 1'b1;
          fail_err = E_VERSION;
        end else begin
          case (phase)
            PH_PING: begin
              if (s1.frame_cmd != CMD_ACK || s1.payload_len != LEN_PING) begin
                fail     = 1'b1;
                fail_err = E_UNEXPECTED;
              end else begin
                issue_req   = 1'b1;
                issue_ph    = PH_VERSION;
                issue_fresh = 1'b1;
              end
            end
            PH_VERSION: begin
              if (s1.frame_cmd != CMD_DATA || s1.payload_len != LEN_VERSION) begin
                fail     = 1'b1;
                fail_err = E_UNEXPECTED;
              end else begin
                proto_ver_next = s1.peer_version;
                fw_major_next  = s1.payload_b2;
                fw_minor_next  = s1.payload_b3;
                fw_patch_next  = s1.payload_b4;
                issue_req      = 1'b1;
                issue_ph       = PH_STATUS;
                issue_fresh    = 1'b1;
              end
            end
            default: begin
              if (s1.frame_cmd != CMD_DATA || s1.payload_len != LEN_STATUS) begin
                fail     = 1'b1;
                fail_err = E_UNEXPECTED;
              end else begin
                ready_mask_next    = s1.payload_b2;
                supp_mask_next     = s1.payload_b3;
                health_next        = H_READY;
                error_next         = E_NONE;
                disc_cnt_next      = disc_cnt + 32'd1;
                phase_next         = PH_IDLE;
                attempt_count_next = '0;
                last_act_next      = now_t;
              end
            end
          endcase
        end
      end
      REQ_PARSE_ERR: begin
        error_next = E_MALFORMED;
        if (health == H_READY) begin
          health_next = H_DEGRADED;
        end
      end
      default: begin
        if (phase != PH_IDLE) begin
          if (rsp_expired) begin
            if (attempt_count < max_attempts) begin
              attempt_count_next = attempt_count + 8'd1;
              issue_req          = 1'b1;
              issue_ph           = phase;
            end else begin
              fail     = 1'b1;
              fail_err = E_TIMEOUT;
            end
          end
        end else if (idle_expired) begin
          if (health == H_OFFLINE) begin
            health_next = H_DISCOVERING;
          end
          issue_req   = 1'b1;
          issue_ph    = PH_PING;
          issue_fresh = 1'b1;
        end
      end
    endcase

    // Send the request, or fail the link when the write is refused.
    if (issue_req) begin
      if (!s1.write_ok) begin
        fail     = 1'b1;
        fail_err = E_WRITE;
      end else begin
        sent           = 1'b1;
        sent_ph        = issue_ph;
        phase_next     = issue_ph;
        req_start_next = now_t;
        last_act_next  = now_t;
        if (issue_fresh) begin
          attempt_count_next = 8'd1;
        end
      end
    end

    if (fail) begin
      health_next        = H_OFFLINE;
      error_next         = fail_err;
      fail_cnt_next      = fail_cnt + 32'd1;
      phase_next         = PH_IDLE;
      attempt_count_next = '0;
      last_act_next      = now_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      attempt_count <= '0;
      req_start     <= '0;
      last_act      <= '0;
      health        <= H_OFFLINE;
      error         <= E_NONE;
      proto_ver     <= '0;
      fw_major      <= '0;
      fw_minor      <= '0;
      fw_patch      <= '0;
      ready_mask    <= '0;
      supp_mask     <= '0;
      fail_cnt      <= '0;
      disc_cnt      <= '0;
    end else if (s1_fire) begin
      phase         <= phase_next;
      attempt_count <= attempt_count_next;
      req_start     <= req_start_next;
      last_act      <= last_act_next;
      health        <= health_next;
      error         <= error_next;
      proto_ver     <= proto_ver_next;
      fw_major      <= fw_major_next;
      fw_minor      <= fw_minor_next;
      fw_patch      <= fw_patch_next;
      ready_mask    <= ready_mask_next;
      supp_mask     <= supp_mask_next;
      fail_cnt      <= fail_cnt_next;
      disc_cnt      <= disc_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data.send_valid      <= sent;
      out_data.send_cmd        <= sent ? 2'(sent_ph) : 2'd0;
      out_data.health          <= health_next;
      out_data.last_error      <= error_next;
      out_data.proto_version   <= proto_ver_next;
      out_data.fw_major        <= fw_major_next;
      out_data.fw_minor        <= fw_minor_next;
      out_data.fw_patch        <= fw_patch_next;
      out_data.ready_bits      <= ready_mask_next;
      out_data.supported_bits  <= supp_mask_next;
      out_data.failure_count   <= fail_cnt_next;
      out_data.discovery_count <= disc_cnt_next;
    end
  end

  // Idle phase never carries a live attempt count.
  `PDH_ASSERT(a_idle_no_attempts, clk, rst, (phase != PH_IDLE) || (attempt_count == 8'd0))
  // A request in flight implies the link is not offline.
  `PDH_ASSERT(a_busy_not_offline, clk, rst, (phase == PH_IDLE) || (health != H_OFFLINE))
  // A sent request is never reported with the link offline.
  `PDH_ASSERT(a_send_online, clk, rst, (out_valid && out_data.send_valid) |-> (out_data.health != H_OFFLINE))
  // Failure counter moves by one at most, and only when an event retires.
  `PDH_ASSERT(a_fail_step, clk, rst, ##1 ((fail_cnt == $past(fail_cnt)) || ($past(s1_fire) && (fail_cnt == $past(fail_cnt) + 32'd1))))
  // Input backpressure only when the input stage is full and blocked.
  `PDH_ASSERT(a_ready_stall, clk, rst, !in_ready |-> (s1_valid && out_valid && !out_ready))

endmodule

// File: sim/pdh_checker.sv
// Scoreboard for peer_discovery_handshake_core: watches the event, result and register ports,
// predicts every result word and compares it field by field.
// Depends on pdh_pkg.
module pdh_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  pdh_pkg::in_word_t                in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  pdh_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [pdh_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [31:0]                      cfg_wdata,
  output int unsigned                      fail_count,
  output int unsigned                      pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pdh_pkg::*;

  // settings as the block should hold them
  logic [15:0] tmo_ms;
  logic [7:0]  attempt_limit;
  logic [31:0] heartbeat_ms;
  logic [31:0] rediscover_ms;
  logic [7:0]  want_version;

  // link state
  phase_t      cur_phase;
  logic [7:0]  attempts;
  logic [31:0] request_t0;
  logic [31:0] last_active;
  health_t     link_health;
  err_t        link_err;
  logic [7:0]  proto_cap, major_cap, minor_cap, patch_cap;
  logic [7:0]  ready_mask, supported_mask;
  logic [31:0] failures, discoveries;

  logic        req_sent;
  phase_t      req_sent_cmd;

  out_word_t   result_q[$];

  task automatic reset_link();
    tmo_ms = TIMEOUT_RST;
    attempt_limit = MAX_ATT_RST;
    heartbeat_ms = HEARTBEAT_RST;
    rediscover_ms = REDISCOVER_RST;
    want_version = EXP_VER_RST;
    cur_phase = PH_IDLE;
    attempts = '0;
    request_t0 = '0;
    last_active = '0;
    link_health = H_OFFLINE;
    link_err = E_NONE;
    {proto_cap, major_cap, minor_cap, patch_cap} = '0;
    {ready_mask, supported_mask} = '0;
    failures = '0;
    discoveries = '0;
  endtask

  function automatic bit interval_passed(input logic [31:0] now, input logic [31:0] since,
                                         input logic [31:0] span);
    logic [31:0] gap;
    gap = now - since;
    return gap >= span;
  endfunction

  task automatic drop_link(input err_t why, input logic [31:0] now);
    link_health = H_OFFLINE;
    link_err = why;
    failures = failures + 32'd1;
    cur_phase = PH_IDLE;
    attempts = '0;
    last_active = now;
  endtask

  task automatic send_request(input phase_t p, input logic [31:0] now, input bit fresh,
                              input logic write_ok);
    if (!write_ok) begin
      drop_link(E_WRITE, now);
      return;
    end
    req_sent = 1'b1;
    req_sent_cmd = p;
    cur_phase = p;
    request_t0 = now;
    last_active = now;
    if (fresh) attempts = 8'd1;
  endtask

  task automatic take_frame(input in_word_t w);
    // a peer error frame wins over every other check
    if (w.frame_cmd == CMD_ERROR) begin
      drop_link(E_PEER, w.now_ms);
      return;
    end
    if (cur_phase == PH_IDLE || w.payload_len < LEN_MIN || w.echo_req != {6'd0, cur_phase}) begin
      drop_link(E_UNEXPECTED, w.now_ms);
      return;
    end
    if (w.peer_version != want_version) begin
      drop_link(E_VERSION, w.now_ms);
      return;
    end
    case (cur_phase)
      PH_PING: begin
        if (w.frame_cmd != CMD_ACK || w.payload_len != LEN_PING) drop_link(E_UNEXPECTED, w.now_ms);
        else send_request(PH_VERSION, w.now_ms, 1'b1, w.write_ok);
      end
      PH_VERSION: begin
        if (w.frame_cmd != CMD_DATA || w.payload_len != LEN_VERSION) begin
          drop_link(E_UNEXPECTED, w.now_ms);
        end else begin
          proto_cap = w.peer_version;
          major_cap = w.payload_b2;
          minor_cap = w.payload_b3;
          patch_cap = w.payload_b4;
          send_request(PH_STATUS, w.now_ms, 1'b1, w.write_ok);
        end
      end
      default: begin
        if (w.frame_cmd != CMD_DATA || w.payload_len != LEN_STATUS) begin
          drop_link(E_UNEXPECTED, w.now_ms);
        end else begin
          ready_mask = w.payload_b2;
          supported_mask = w.payload_b3;
          link_health = H_READY;
          link_err = E_NONE;
          discoveries = discoveries + 32'd1;
          cur_phase = PH_IDLE;
          attempts = '0;
          last_active = w.now_ms;
        end
      end
    endcase
  endtask

  task automatic take_tick(input in_word_t w);
    logic [31:0] span;
    if (cur_phase != PH_IDLE) begin
      if (interval_passed(w.now_ms, request_t0, {16'd0, tmo_ms})) begin
        if (attempts < attempt_limit) begin
          attempts = attempts + 8'd1;
          send_request(cur_phase, w.now_ms, 1'b0, w.write_ok);
        end else begin
          drop_link(E_TIMEOUT, w.now_ms);
        end
      end
      return;
    end
    span = (link_health == H_OFFLINE) ? rediscover_ms : heartbeat_ms;
    if (interval_passed(w.now_ms, last_active, span)) begin
      if (link_health == H_OFFLINE) link_health = H_DISCOVERING;
      send_request(PH_PING, w.now_ms, 1'b1, w.write_ok);
    end
  endtask

  task automatic predict_result(input in_word_t w, output out_word_t r);
    req_sent = 1'b0;
    req_sent_cmd = PH_PING;
    case (w.req_type)
      REQ_BEGIN: begin
        link_health = H_DISCOVERING;
        link_err = E_NONE;
        send_request(PH_PING, w.now_ms, 1'b1, w.write_ok);
      end
      REQ_FRAME: take_frame(w);
      REQ_PARSE_ERR: begin
        link_err = E_MALFORMED;
        if (link_health == H_READY) link_health = H_DEGRADED;
      end
      default: take_tick(w);
    endcase
    r.send_valid = req_sent;
    // command field reads as zero when nothing went out
    r.send_cmd = req_sent ? req_sent_cmd : PH_PING;
    r.health = link_health;
    r.last_error = link_err;
    r.proto_version = proto_cap;
    r.fw_major = major_cap;
    r.fw_minor = minor_cap;
    r.fw_patch = patch_cap;
    r.ready_bits = ready_mask;
    r.supported_bits = supported_mask;
    r.failure_count = failures;
    r.discovery_count = discoveries;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input out_word_t want, input out_word_t got);
    check_field("send_valid", want.send_valid, got.send_valid);
    check_field("send_cmd", want.send_cmd, got.send_cmd);
    check_field("health", want.health, got.health);
    check_field("last_error", want.last_error, got.last_error);
    check_field("proto_version", want.proto_version, got.proto_version);
    check_field("fw_major", want.fw_major, got.fw_major);
    check_field("fw_minor", want.fw_minor, got.fw_minor);
    check_field("fw_patch", want.fw_patch, got.fw_patch);
    check_field("ready_bits", want.ready_bits, got.ready_bits);
    check_field("supported_bits", want.supported_bits, got.supported_bits);
    check_field("failure_count", want.failure_count, got.failure_count);
    check_field("discovery_count", want.discovery_count, got.discovery_count);
  endtask

  always @(posedge clk) begin
    out_word_t next_result;
    out_word_t oldest;
    if (rst) begin
      reset_link();
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TIMEOUT:    tmo_ms = cfg_wdata[15:0];
          CFG_MAX_ATT:    attempt_limit = cfg_wdata[7:0];
          CFG_HEARTBEAT:  heartbeat_ms = cfg_wdata;
          CFG_REDISCOVER: rediscover_ms = cfg_wdata;
          CFG_EXP_VER:    want_version = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // compare before predicting: a word taken now cannot be answered at this edge
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          oldest = result_q.pop_front();
          check_result(oldest, out_data);
        end
      end
      if (in_valid && in_ready) begin
        predict_result(in_data, next_result);
        result_q.push_back(next_result);
      end
    end
    pending = result_q.size();
  end

endmodule

// File: sim/tb_peer_discovery_handshake_core.sv
// Testbench top for peer_discovery_handshake_core: clock, reset, register writes and event
// words under several idle/stall mixes; pdh_checker does the prediction and comparison.
// Depends on pdh_pkg, pdh_checker and the core.
module tb_peer_discovery_handshake_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pdh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned WORDS_PER_PHASE = 104;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;
  localparam logic [2:0] CMD_OTHER = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;

  // what the stimulus knows of the settings, to aim its time steps
  logic [31:0] clock_ms = '0;
  logic [15:0] cur_timeout = TIMEOUT_RST;
  logic [31:0] cur_heartbeat = HEARTBEAT_RST;
  logic [31:0] cur_rediscover = REDISCOVER_RST;
  logic [7:0]  cur_version = EXP_VER_RST;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;

  peer_discovery_handshake_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pdh_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic push_word(input in_word_t w, input logic [31:0] step_ms);
    clock_ms = clock_ms + step_ms;
    w.now_ms = clock_ms;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic fire(input req_t kind, input logic [31:0] step_ms, input logic write_ok,
                      input logic [2:0] cmd, input logic [7:0] len, input logic [7:0] echo,
                      input logic [7:0] ver, input logic [7:0] b2, input logic [7:0] b3,
                      input logic [7:0] b4);
    in_word_t w;
    w = '{req_type: kind, now_ms: '0, write_ok: write_ok, frame_cmd: cmd, payload_len: len,
          echo_req: echo, peer_version: ver, payload_b2: b2, payload_b3: b3, payload_b4: b4};
    push_word(w, step_ms);
  endtask

  function automatic in_word_t noisy_word(input req_t kind);
    in_word_t w;
    w.req_type = kind;
    w.now_ms = '0;
    w.write_ok = ($urandom_range(9) != 0);
    w.frame_cmd = 3'($urandom());
    w.payload_len = 8'($urandom());
    w.echo_req = 8'($urandom());
    w.peer_version = 8'($urandom());
    w.payload_b2 = 8'($urandom());
    w.payload_b3 = 8'($urandom());
    w.payload_b4 = 8'($urandom());
    return w;
  endfunction

  // time steps aimed at the edges of the reply timeout and the idle intervals
  function automatic logic [31:0] pick_step();
    case ($urandom_range(9))
      4: return {16'd0, cur_timeout};
      5: return {16'd0, cur_timeout} - 32'd1;
      6: return {16'd0, cur_timeout} + $urandom_range(50);
      7: return cur_heartbeat - $urandom_range(1);
      8: return cur_rediscover - $urandom_range(1);
      9: return $urandom();
      default: return $urandom_range(20);
    endcase
  endfunction

  task automatic send_tick();
    push_word(noisy_word(REQ_TICK), pick_step());
  endtask

  task automatic send_reply(input phase_t p);
    in_word_t w;
    w = noisy_word(REQ_FRAME);
    w.frame_cmd = (p == PH_PING) ? CMD_ACK : CMD_DATA;
    w.payload_len = (p == PH_PING) ? LEN_PING : (p == PH_VERSION) ? LEN_VERSION : LEN_STATUS;
    w.echo_req = 8'(p);
    w.peer_version = cur_version;
    // break one in ten replies in a single field
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: w.frame_cmd = 3'($urandom());
        1: w.payload_len = 8'($urandom_range(7));
        2: w.echo_req = 8'($urandom_range(3));
        default: w.peer_version = 8'($urandom());
      endcase
    end
    push_word(w, $urandom_range(20));
  endtask

  task automatic run_discovery(input bit complete);
    int unsigned stop_at;
    int k;
    stop_at = complete ? 3 : $urandom_range(2);
    push_word(noisy_word(REQ_BEGIN), $urandom_range(20));
    for (k = 0; k < 3; k++) begin
      if ($urandom_range(3) == 0) send_tick();
      if (k == stop_at) break;
      send_reply(phase_t'(k));
    end
    // leave the request unanswered: drive resends and the timeout failure
    if (!complete) repeat ($urandom_range(1, 6)) send_tick();
  endtask

  task automatic random_episode();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) run_discovery(1'b1);
    else if (pick < 70) run_discovery(1'b0);
    else if (pick < 85) repeat ($urandom_range(1, 4)) send_tick();
    else if (pick < 92) push_word(noisy_word(REQ_PARSE_ERR), $urandom_range(20));
    else push_word(noisy_word(req_t'($urandom_range(3))), pick_step());
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_TIMEOUT:    cur_timeout = val[15:0];
      CFG_HEARTBEAT:  cur_heartbeat = val;
      CFG_REDISCOVER: cur_rediscover = val;
      CFG_EXP_VER:    cur_version = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int unsigned p);
    logic [31:0] tmo, att, hb, rd, ver;
    // upper bits beyond each register's width are junk and must be dropped
    tmo = {16'($urandom()), 16'($urandom_range(10, 300))};
    att = {24'($urandom()), 8'($urandom_range(1, 4))};
    hb = $urandom_range(100, 3000);
    rd = $urandom_range(100, 6000);
    ver = $urandom();
    case (p)
      1: begin
        tmo = 32'd1;
        att = 32'd1;
        hb = 32'd1;
        rd = 32'd1;
        ver = 32'd0;
      end
      2: begin
        tmo = 32'h0000_FFFF;
        att = 32'h0000_00FF;
        hb = 32'hFFFF_FFFF;
        rd = 32'hFFFF_FFFF;
        ver = 32'h0000_00FF;
      end
      3: begin
        // zero timeout expires at once; zero attempts fail on the first expiry
        tmo = 32'hA5A5_0000;
        att = 32'hFFFF_FF00;
        write_reg(CFG_SPARE, $urandom());
      end
      default: ;
    endcase
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_MAX_ATT, att);
    write_reg(CFG_HEARTBEAT, hb);
    write_reg(CFG_REDISCOVER, rd);
    write_reg(CFG_EXP_VER, ver);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic directed_words();
    fire(REQ_TICK, 10, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_TICK, 4990, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_FRAME, 10, 1'b1, CMD_ACK, LEN_PING, 8'(PH_PING), EXP_VER_RST, 0, 0, 0);
    fire(REQ_FRAME, 5, 1'b1, CMD_DATA, LEN_VERSION, 8'(PH_VERSION), EXP_VER_RST,
         8'hFF, 8'h00, 8'hAA);
    fire(REQ_FRAME, 5, 1'b1, CMD_DATA, LEN_STATUS, 8'(PH_STATUS), EXP_VER_RST,
         8'h55, 8'hFF, 8'h00);
    fire(REQ_PARSE_ERR, 1, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    // heartbeat from degraded, two resends, then the timeout failure
    fire(REQ_TICK, 1000, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_TICK, 50, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_TICK, 50, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_TICK, 100, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_TICK, 100, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_FRAME, 1, 1'b1, CMD_ACK, LEN_PING, 8'(PH_PING), EXP_VER_RST, 0, 0, 0);
    fire(REQ_BEGIN, 1, 1'b0, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_BEGIN, 1, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_FRAME, 1, 1'b1, CMD_ERROR, LEN_PING, 8'(PH_PING), EXP_VER_RST, 0, 0, 0);
    fire(REQ_BEGIN, 1, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_FRAME, 1, 1'b1, CMD_ACK, LEN_PING, 8'(PH_PING), 8'h7E, 0, 0, 0);
    fire(REQ_BEGIN, 1, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_FRAME, 1, 1'b1, CMD_ACK, LEN_MIN - 8'd1, 8'(PH_PING), EXP_VER_RST, 0, 0, 0);
    fire(REQ_BEGIN, 1, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_FRAME, 1, 1'b1, CMD_ACK, LEN_PING, 8'(PH_VERSION), EXP_VER_RST, 0, 0, 0);
    fire(REQ_BEGIN, 1, 1'b1, CMD_OTHER, 0, 0, 0, 0, 0, 0);
    fire(REQ_FRAME, 1, 1'b0, CMD_ACK, LEN_PING, 8'(PH_PING), EXP_VER_RST, 0, 0, 0);
    fire(REQ_FRAME, 1, 1'b1, CMD_OTHER, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    fire(REQ_FRAME, 1, 1'b1, CMD_ERROR, 0, 0, 0, 0, 0, 0);
    // jump to the top of the time range with the write path refused
    fire(REQ_TICK, 32'hFFFF_FFFF - clock_ms, 1'b0, CMD_OTHER, 0, 0, 0, 0, 0, 0);
  endtask

  initial begin
    int unsigned p;
    int unsigned phase_start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_words();
    for (p = 0; p < PHASE_COUNT; p++) begin
      drain();
      load_settings(p);
      case (p % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 73;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 73;
        end
        default: begin
          src_idle_pct = 16;
          sink_stall_pct = 16;
        end
      endcase
      // back up the pipe while words keep coming
      if (p == 0) hold_req++;
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) random_episode();
    end
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
